// ----- hw/rtl/adc_avg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC accumulate and average package
// Widths, channel codes, register indexes and the controller/datapath
// interface types shared by the averager modules.
// ----------------------------------------------------------------------------
package adc_avg_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int SUM_WIDTH    = 32;
	localparam int FIELD_W      = 16;
	localparam int CNT_W        = 16;
	localparam int CFG_W        = 16;
	localparam int NUM_CH       = 4;
	localparam int CH_W         = 2;
	localparam int CFG_IDX_W    = 8;
	localparam int GAIN_FRAC    = 8;

	localparam int S_TDATA_W = NUM_CH * FIELD_W;
	localparam int M_TDATA_W = (NUM_CH + 1) * FIELD_W;

	// The divider retires two quotient bits per cycle.
	localparam int DIV_W     = ((SUM_WIDTH + 1) / 2) * 2;
	localparam int DIV_ITERS = DIV_W / 2;
	localparam int ITER_W    = $clog2(DIV_ITERS);
	localparam int REM_W     = CNT_W + 1;

	localparam int PROD_MIN_W = GAIN_FRAC + FIELD_W + 2;
	localparam int PROD_W = (SAMPLE_WIDTH + CFG_W + 1 > PROD_MIN_W) ?
		(SAMPLE_WIDTH + CFG_W + 1) : PROD_MIN_W;

	localparam logic [CFG_IDX_W-1:0] REG_READY_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN    = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] READY_THRESHOLD_RST = CFG_W'(327);
	localparam logic [CFG_W-1:0] VOLTAGE_GAIN_RST    = CFG_W'(825);

	typedef enum logic [CH_W-1:0] {
		CH_XRATE,
		CH_YRATE,
		CH_VOLTAGE,
		CH_TEMP
	} chan_t;

	typedef struct packed {
		logic  accum;
		logic  div_load;
		logic  div_step;
		logic  div_store;
		chan_t ch;
		logic  mul;
		logic  scale;
		logic  publish;
		logic  updated;
	} dp_cmd_t;

	typedef struct packed {
		logic over_thresh;
		logic out_busy;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/adc_avg_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC averager controller
// Sequences accumulation, the per-channel divisions, the voltage scaling and
// the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module adc_avg_ctrl
	import adc_avg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_STEP,
		ST_STORE,
		ST_MUL,
		ST_SCALE,
		ST_PUB
	} state_t;

	state_t            state_q;
	chan_t             ch_q;
	logic [ITER_W-1:0] iter_q;
	logic              updated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ch_q      <= CH_XRATE;
			iter_q    <= '0;
			updated_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					ch_q <= CH_XRATE;
					if (status.over_thresh) begin
						updated_q <= 1'b1;
						state_q   <= ST_LOAD;
					end else begin
						updated_q <= 1'b0;
						state_q   <= ST_PUB;
					end
				end
				ST_LOAD: begin
					iter_q  <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					iter_q <= iter_q + ITER_W'(1);
					if (iter_q == ITER_W'(DIV_ITERS - 1)) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (ch_q == CH_TEMP) begin
						state_q <= ST_MUL;
					end else begin
						ch_q    <= chan_t'(ch_q + CH_W'(1));
						state_q <= ST_LOAD;
					end
				end
				ST_MUL: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_PUB;
				end
				ST_PUB: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		s_tready      = (state_q == ST_IDLE);
		cmd.accum     = (state_q == ST_IDLE) && s_tvalid;
		cmd.div_load  = (state_q == ST_LOAD);
		cmd.div_step  = (state_q == ST_STEP);
		cmd.div_store = (state_q == ST_STORE);
		cmd.ch        = ch_q;
		cmd.mul       = (state_q == ST_MUL);
		cmd.scale     = (state_q == ST_SCALE);
		cmd.publish   = (state_q == ST_PUB) && !status.out_busy;
		cmd.updated   = updated_q;
	end

	// A result must never be pushed into an output register that is still full.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !status.out_busy)
		else $error("result published while output register busy");

	// The voltage is scaled only after every channel has been divided.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> $past(cmd.div_store) && $past(ch_q) == CH_TEMP)
		else $error("voltage multiply started before divisions finished");

	// An accepted request always starts with the threshold check.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_CHECK)
		else $error("accepted request did not start processing");

endmodule
`default_nettype wire

// ----- hw/rtl/adc_avg_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC averager datapath
// Saturating channel sums and sample count, a shared radix-4 restoring
// divider, the voltage gain multiplier and the output register.
// ----------------------------------------------------------------------------
module adc_avg_dp
	import adc_avg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire dp_cmd_t               cmd,
	output dp_status_t                 status,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,
	output logic                       m_tuser
);

	localparam logic [DIV_W-1:0] POS_LIM = DIV_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'(1 << (SAMPLE_WIDTH - 1));

	logic [CFG_W-1:0]               thresh_q;
	logic [CFG_W-1:0]               gain_q;
	logic signed [SUM_WIDTH-1:0]    sum_q [NUM_CH];
	logic [CNT_W-1:0]               cnt_q;
	logic [FIELD_W-1:0]             held_q [NUM_CH];

	logic [DIV_W-1:0]               quo_q;
	logic [REM_W-1:0]               rem_q;
	logic                           neg_q;
	logic signed [SAMPLE_WIDTH-1:0] vavg_q;
	logic signed [PROD_W-1:0]       prod_q;

	logic                           m_tvalid_q;
	logic [M_TDATA_W-1:0]           m_tdata_q;
	logic                           m_tuser_q;

	logic signed [SUM_WIDTH:0]      wide [NUM_CH];
	logic signed [SUM_WIDTH-1:0]    sum_next [NUM_CH];
	logic [CNT_W-1:0]               cnt_base;
	logic [CNT_W-1:0]               cnt_next;

	logic signed [SUM_WIDTH-1:0]    div_sel;
	logic [SUM_WIDTH-1:0]           div_mag;
	logic [REM_W-1:0]               rem1, rem2;
	logic [DIV_W-1:0]               quo1, quo2;
	logic [DIV_W-1:0]               neg_mag;
	logic signed [SAMPLE_WIDTH-1:0] avg_sat;
	logic [FIELD_W-1:0]             volt_sat;

	// Sum and count update for the accepted scan.
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			wide[i] = (s_tuser ? (SUM_WIDTH + 1)'(0) : {sum_q[i][SUM_WIDTH-1], sum_q[i]})
				+ (SUM_WIDTH + 1)'(signed'(s_tdata[i*FIELD_W +: SAMPLE_WIDTH]));
			if (wide[i][SUM_WIDTH] != wide[i][SUM_WIDTH-1]) begin
				sum_next[i] = {wide[i][SUM_WIDTH], {(SUM_WIDTH - 1){~wide[i][SUM_WIDTH]}}};
			end else begin
				sum_next[i] = wide[i][SUM_WIDTH-1:0];
			end
		end
		cnt_base = s_tuser ? '0 : cnt_q;
		cnt_next = (&cnt_base) ? cnt_base : cnt_base + CNT_W'(1);
	end

	// Two restoring division steps per cycle on the magnitude of the sum.
	always_comb begin
		div_sel = sum_q[cmd.ch];
		div_mag = div_sel[SUM_WIDTH-1] ? SUM_WIDTH'(-div_sel) : SUM_WIDTH'(div_sel);

		rem1 = {rem_q[REM_W-2:0], quo_q[DIV_W-1]};
		quo1 = {quo_q[DIV_W-2:0], 1'b0};
		if (rem1 >= {1'b0, cnt_q}) begin
			rem1    = rem1 - {1'b0, cnt_q};
			quo1[0] = 1'b1;
		end
		rem2 = {rem1[REM_W-2:0], quo1[DIV_W-1]};
		quo2 = {quo1[DIV_W-2:0], 1'b0};
		if (rem2 >= {1'b0, cnt_q}) begin
			rem2    = rem2 - {1'b0, cnt_q};
			quo2[0] = 1'b1;
		end

		neg_mag = -quo_q;
		if (!neg_q) begin
			if (quo_q > POS_LIM) begin
				avg_sat = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
			end else begin
				avg_sat = quo_q[SAMPLE_WIDTH-1:0];
			end
		end else begin
			if (quo_q > NEG_LIM) begin
				avg_sat = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
			end else begin
				avg_sat = neg_mag[SAMPLE_WIDTH-1:0];
			end
		end

		if (prod_q[PROD_W-1]) begin
			volt_sat = '0;
		end else if (|prod_q[PROD_W-2:GAIN_FRAC+FIELD_W]) begin
			volt_sat = '1;
		end else begin
			volt_sat = prod_q[GAIN_FRAC +: FIELD_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q   <= READY_THRESHOLD_RST;
			gain_q     <= VOLTAGE_GAIN_RST;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < NUM_CH; i++) begin
				sum_q[i]  <= '0;
				held_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_READY_THRESHOLD) begin
					thresh_q <= cfg_data;
				end else if (cfg_index == REG_VOLTAGE_GAIN) begin
					gain_q <= cfg_data;
				end
			end
			if (cmd.accum) begin
				cnt_q <= cnt_next;
				for (int i = 0; i < NUM_CH; i++) begin
					sum_q[i] <= sum_next[i];
				end
			end
			if (cmd.div_store && cmd.ch != CH_VOLTAGE) begin
				held_q[cmd.ch] <= FIELD_W'(avg_sat);
			end
			if (cmd.scale) begin
				held_q[CH_VOLTAGE] <= volt_sat;
			end
			if (cmd.publish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			quo_q <= DIV_W'(div_mag);
			rem_q <= '0;
			neg_q <= div_sel[SUM_WIDTH-1];
		end else if (cmd.div_step) begin
			quo_q <= quo2;
			rem_q <= rem2;
		end
		if (cmd.div_store && cmd.ch == CH_VOLTAGE) begin
			vavg_q <= avg_sat;
		end
		if (cmd.mul) begin
			prod_q <= vavg_q * signed'({1'b0, gain_q});
		end
		if (cmd.publish) begin
			m_tdata_q <= {cnt_q, held_q[CH_TEMP], held_q[CH_VOLTAGE],
				held_q[CH_YRATE], held_q[CH_XRATE]};
			m_tuser_q <= cmd.updated;
		end
	end

	assign status.over_thresh = (cnt_q > thresh_q);
	assign status.out_busy    = m_tvalid_q && !m_tready;
	assign m_tvalid           = m_tvalid_q;
	assign m_tdata            = m_tdata_q;
	assign m_tuser            = m_tuser_q;

	// The count never wraps, so a division is never started with a zero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |-> cnt_q != '0)
		else $error("division started with zero sample count");

	// A quotient is stored only after the last iteration of the divider.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_store |-> $past(cmd.div_step))
		else $error("quotient stored before division finished");

	// Without a read request the count advances by one until it saturates.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accum && !s_tuser && cnt_q != '1 |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("sample count did not advance");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> m_tvalid)
		else $error("published result not presented");

endmodule
`default_nettype wire

// ----- hw/rtl/adc_accumulate_average.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC accumulate and average
// Integrate-and-dump averager over four-channel ADC scans with a scaled
// voltage output and a saturating sample count.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Carries
//  s_*       tvalid tready tdata[63:0] tuser  one scan request and read flag
//  m_*       tvalid tready tdata[79:0] tuser  held averages, count, update flag
//  cfg_*     valid ready index[7:0] data[15:0] register write
//
// A scan that leaves the count at or below the threshold goes from the
// threshold check straight to the output register. A scan that refreshes the
// averages runs the single divider, which retires two quotient bits per cycle
// and serves the four channels in turn, and then scales the voltage.
// Reset clears sums, count and held averages and loads the register defaults.
// A stalled result waits in the output register; the next scan is accepted
// meanwhile and its result is held back until the register frees.
// ----------------------------------------------------------------------------
module adc_accumulate_average
	import adc_avg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// xrate_sample, yrate_sample, voltage_sample, temp_sample
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	// read_request
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// xrate_average, yrate_average, voltage_scaled, temp_average, samples_summed
	output logic [M_TDATA_W-1:0]       m_tdata,
	// averages_updated
	output logic                       m_tuser,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// The user must write registers only while the block is idle; this is not enforced, so no back-pressure.
	assign cfg_ready = 1'b1;

	adc_avg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	adc_avg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC accumulate and average testbench
// Drives scans of four channels through the stream input, keeps a running
// model of the sums, sample count and held averages, and compares each
// result against it field by field. It opens with a table of directed scans
// and register writes. Random phases end the run, each with its own settings
// and its own amount of idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import adc_avg_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 8;
	localparam int TAIL_CYCLES  = 200;
	localparam int TIMEOUT_NS   = 30_000_000;
	localparam int MAX_REPORTS  = 50;
	localparam int PHASE_SCANS  = 190;

	localparam longint SUM_HI  = (longint'(1) << (SUM_WIDTH - 1)) - 1;
	localparam longint SUM_LO  = -SUM_HI - 1;
	localparam longint AVG_HI  = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
	localparam longint AVG_LO  = -AVG_HI - 1;
	localparam longint VOLT_HI = (longint'(1) << FIELD_W) - 1;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_VOLTAGE_GAIN + CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

	typedef struct {
		logic [FIELD_W-1:0] xrate;
		logic [FIELD_W-1:0] yrate;
		logic [FIELD_W-1:0] voltage;
		logic [FIELD_W-1:0] temp;
		logic               read_request;
	} scan_t;

	typedef struct {
		logic [FIELD_W-1:0] xrate_average;
		logic [FIELD_W-1:0] yrate_average;
		logic [FIELD_W-1:0] voltage_scaled;
		logic [FIELD_W-1:0] temp_average;
		logic [CNT_W-1:0]   samples_summed;
		logic               averages_updated;
	} scan_result_t;

	typedef enum { ROW_SCAN, ROW_CONFIG } row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   index;
		logic [CFG_W-1:0]       data;
		scan_t                  scan;
		bit                     typed;
		scan_result_t           result;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// xrate_sample, yrate_sample, voltage_sample, temp_sample
	logic [S_TDATA_W-1:0]  s_tdata;
	// read_request
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// xrate_average, yrate_average, voltage_scaled, temp_average, samples_summed
	logic [M_TDATA_W-1:0]  m_tdata;
	// averages_updated
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	adc_accumulate_average dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Running copy of the averager state and its registers.
	longint             acc_xrate = 0;
	longint             acc_yrate = 0;
	longint             acc_voltage = 0;
	longint             acc_temp = 0;
	logic [CNT_W-1:0]   scan_count = '0;
	logic [FIELD_W-1:0] hold_xrate = '0;
	logic [FIELD_W-1:0] hold_yrate = '0;
	logic [FIELD_W-1:0] hold_voltage = '0;
	logic [FIELD_W-1:0] hold_temp = '0;
	logic [CFG_W-1:0]   cur_threshold = READY_THRESHOLD_RST;
	logic [CFG_W-1:0]   cur_gain = VOLTAGE_GAIN_RST;

	scan_result_t expected_results[$];
	stim_row_t    directed_rows[$];
	scan_result_t no_result;

	int mismatches = 0;
	int result_index = 0;
	int sender_idle_pct = 0;
	int sink_stall_pct = 0;
	int window_left = 0;

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic longint sample_value(logic [FIELD_W-1:0] f);
		logic signed [SAMPLE_WIDTH-1:0] s;
		s = f[SAMPLE_WIDTH-1:0];
		return longint'(s);
	endfunction

	function automatic longint channel_average(longint sum, logic [CNT_W-1:0] n);
		return clamp(sum / longint'(n), AVG_LO, AVG_HI);
	endfunction

	function automatic scan_result_t predict_scan(scan_t s);
		scan_result_t r;
		longint       v;
		longint       p;
		logic [FIELD_W-1:0] q;
		r.averages_updated = 1'b0;
		if (s.read_request) begin
			acc_xrate = 0;
			acc_yrate = 0;
			acc_voltage = 0;
			acc_temp = 0;
			scan_count = '0;
		end
		acc_xrate   = clamp(acc_xrate + sample_value(s.xrate), SUM_LO, SUM_HI);
		acc_yrate   = clamp(acc_yrate + sample_value(s.yrate), SUM_LO, SUM_HI);
		acc_voltage = clamp(acc_voltage + sample_value(s.voltage), SUM_LO, SUM_HI);
		acc_temp    = clamp(acc_temp + sample_value(s.temp), SUM_LO, SUM_HI);
		if (scan_count != '1)
			scan_count = scan_count + CNT_W'(1);
		if (scan_count > cur_threshold) begin
			v = channel_average(acc_xrate, scan_count);
			hold_xrate = FIELD_W'(v);
			v = channel_average(acc_yrate, scan_count);
			hold_yrate = FIELD_W'(v);
			v = channel_average(acc_temp, scan_count);
			hold_temp = FIELD_W'(v);
			v = channel_average(acc_voltage, scan_count);
			p = v * longint'(cur_gain);
			if (p < 0) begin
				hold_voltage = '0;
			end else begin
				p = clamp(p / (longint'(1) << GAIN_FRAC), 0, VOLT_HI);
				q = FIELD_W'(p);
				hold_voltage = q;
			end
			r.averages_updated = 1'b1;
		end
		r.xrate_average  = hold_xrate;
		r.yrate_average  = hold_yrate;
		r.voltage_scaled = hold_voltage;
		r.temp_average   = hold_temp;
		r.samples_summed = scan_count;
		return r;
	endfunction

	function automatic scan_t make_scan(int x, int y, int v, int t, bit rr);
		scan_t s;
		s.xrate        = FIELD_W'(x);
		s.yrate        = FIELD_W'(y);
		s.voltage      = FIELD_W'(v);
		s.temp         = FIELD_W'(t);
		s.read_request = rr;
		return s;
	endfunction

	function automatic stim_row_t scan_row(int x, int y, int v, int t, bit rr);
		stim_row_t row;
		row.kind  = ROW_SCAN;
		row.index = '0;
		row.data  = '0;
		row.scan  = make_scan(x, y, v, t, rr);
		row.typed = 1'b0;
		row.result = no_result;
		return row;
	endfunction

	function automatic stim_row_t checked_row(int x, int y, int v, int t, bit rr,
			int ex, int ey, int ev, int et, int cnt, bit upd);
		stim_row_t row;
		row = scan_row(x, y, v, t, rr);
		row.typed = 1'b1;
		row.result.xrate_average    = FIELD_W'(ex);
		row.result.yrate_average    = FIELD_W'(ey);
		row.result.voltage_scaled   = FIELD_W'(ev);
		row.result.temp_average     = FIELD_W'(et);
		row.result.samples_summed   = CNT_W'(cnt);
		row.result.averages_updated = upd;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
		stim_row_t row;
		row = scan_row(0, 0, 0, 0, 1'b0);
		row.kind  = ROW_CONFIG;
		row.index = idx;
		row.data  = CFG_W'(val);
		return row;
	endfunction

	function automatic logic [FIELD_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return FIELD_W'(AVG_HI);
			1: return FIELD_W'(AVG_LO);
			2: return '0;
			3: return '1;
			4: return FIELD_W'($urandom_range(0, 4000));
			5: return FIELD_W'(0 - int'($urandom_range(0, 4000)));
			default: return FIELD_W'($urandom);
		endcase
	endfunction

	// Mostly well-formed windows: a read request followed by a run of scans of
	// random length, up to twice the threshold plus four, with some stray read requests.
	function automatic scan_t random_scan();
		scan_t s;
		s.xrate   = rand_sample();
		s.yrate   = rand_sample();
		s.voltage = rand_sample();
		s.temp    = rand_sample();
		if ($urandom_range(0, 9) == 0) begin
			s.read_request = 1'($urandom_range(0, 1));
		end else if (window_left == 0) begin
			s.read_request = 1'b1;
			window_left = $urandom_range(1, 2 * int'(cur_threshold) + 4);
		end else begin
			s.read_request = 1'b0;
			window_left--;
		end
		return s;
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	task automatic check_field(string name, logic [FIELD_W-1:0] got,
			logic [FIELD_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %h, expected %h",
				result_index, name, got, want));
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		wait_for_drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_READY_THRESHOLD)
			cur_threshold = val;
		else if (idx == REG_VOLTAGE_GAIN)
			cur_gain = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_scan(scan_t s, bit typed, scan_result_t typed_result);
		scan_result_t predicted;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {s.temp, s.voltage, s.yrate, s.xrate};
		s_tuser  <= s.read_request;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = predict_scan(s);
		expected_results.push_back(typed ? typed_result : predicted);
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no request pending",
					result_index));
			end else begin
				want = expected_results.pop_front();
				check_field("xrate_average", m_tdata[0*FIELD_W +: FIELD_W],
					want.xrate_average);
				check_field("yrate_average", m_tdata[1*FIELD_W +: FIELD_W],
					want.yrate_average);
				check_field("voltage_scaled", m_tdata[2*FIELD_W +: FIELD_W],
					want.voltage_scaled);
				check_field("temp_average", m_tdata[3*FIELD_W +: FIELD_W],
					want.temp_average);
				check_field("samples_summed", m_tdata[4*FIELD_W +: FIELD_W],
					want.samples_summed);
				check_field("averages_updated", FIELD_W'(m_tuser),
					FIELD_W'(want.averages_updated));
			end
			result_index++;
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int    pick;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		no_result = '{default: '0};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default threshold: no refresh yet, held values still at reset.
		directed_rows.push_back(checked_row(32767, -32768, 1000, 0, 1,
			0, 0, 0, 0, 1, 0));
		directed_rows.push_back(checked_row(-1, 1, -1, 1, 0, 0, 0, 0, 0, 2, 0));
		// Threshold zero: every scan refreshes, a lone scan is its own average.
		directed_rows.push_back(cfg_row(REG_READY_THRESHOLD, 0));
		directed_rows.push_back(checked_row(32767, -32768, 32767, -1, 1,
			32767, -32768, 65535, -1, 1, 1));
		directed_rows.push_back(checked_row(0, 0, -32768, 0, 1, 0, 0, 0, 0, 1, 1));
		directed_rows.push_back(checked_row(0, 0, 256, 0, 1, 0, 0, 825, 0, 1, 1));
		directed_rows.push_back(scan_row(0, 0, 0, 0, 0));
		directed_rows.push_back(checked_row(-3, 3, 0, 0, 1, -3, 3, 0, 0, 1, 1));
		directed_rows.push_back(scan_row(0, 0, 0, 0, 0));
		// Gain at both ends of its range.
		directed_rows.push_back(cfg_row(REG_VOLTAGE_GAIN, 0));
		directed_rows.push_back(checked_row(5, 6, 32767, 7, 1, 5, 6, 0, 7, 1, 1));
		directed_rows.push_back(cfg_row(REG_VOLTAGE_GAIN, 65535));
		directed_rows.push_back(checked_row(0, 0, 1, 0, 1, 0, 0, 255, 0, 1, 1));
		directed_rows.push_back(checked_row(0, 0, 32767, 0, 1, 0, 0, 65535, 0, 1, 1));
		// Writes past the register list must leave the gain alone.
		directed_rows.push_back(cfg_row(REG_UNUSED_FIRST, 123));
		directed_rows.push_back(cfg_row(REG_UNUSED_LAST, 0));
		directed_rows.push_back(checked_row(0, 0, 1, 0, 1, 0, 0, 255, 0, 1, 1));
		directed_rows.push_back(cfg_row(REG_READY_THRESHOLD, 3));
		directed_rows.push_back(checked_row(100, 200, 300, 400, 1,
			0, 0, 255, 0, 1, 0));
		directed_rows.push_back(scan_row(-7, 9, 1234, -400, 0));
		directed_rows.push_back(scan_row(11, -13, 2000, 77, 0));
		directed_rows.push_back(scan_row(-5, 21, 3000, 1, 0));
		directed_rows.push_back(cfg_row(REG_VOLTAGE_GAIN, 825));
		directed_rows.push_back(cfg_row(REG_READY_THRESHOLD, 65535));
		directed_rows.push_back(scan_row(1000, 1000, 1000, 1000, 1));

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CONFIG)
				write_register(directed_rows[i].index, directed_rows[i].data);
			else
				send_scan(directed_rows[i].scan, directed_rows[i].typed,
					directed_rows[i].result);
		end

		for (int phase = 0; phase < 4; phase++) begin
			wait_for_drain();
			case (phase)
				0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin sender_idle_pct = 87; sink_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  sink_stall_pct = 87; end
				default: begin sender_idle_pct = 6; sink_stall_pct = 6; end
			endcase
			pick = $urandom_range(0, 3);
			case (pick)
				0: write_register(REG_READY_THRESHOLD, 0);
				1: write_register(REG_READY_THRESHOLD, 1);
				2: write_register(REG_READY_THRESHOLD, CFG_W'($urandom_range(2, 12)));
				default: write_register(REG_READY_THRESHOLD,
					CFG_W'($urandom_range(13, 40)));
			endcase
			pick = $urandom_range(0, 3);
			case (pick)
				0: write_register(REG_VOLTAGE_GAIN, VOLTAGE_GAIN_RST);
				1: write_register(REG_VOLTAGE_GAIN, CFG_W'($urandom));
				2: write_register(REG_VOLTAGE_GAIN, CFG_W'(1 << GAIN_FRAC));
				default: write_register(REG_VOLTAGE_GAIN, CFG_W'($urandom_range(0, 2000)));
			endcase
			window_left = 0;
			for (int n = 0; n < PHASE_SCANS; n++) begin
				// Now and then hold off until the block has caught up.
				if (n == PHASE_SCANS / 2 || $urandom_range(0, 59) == 0)
					wait_for_drain();
				send_scan(random_scan(), 1'b0, no_result);
			end
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived",
				expected_results.size()));
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
